// ===== hdl/indexed_max_heap_queue_top_defines.svh =====
// Assertion macros used by the port-level checker file.
`ifndef INDEXED_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define IMHQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/imhq_pkg.sv =====
//------------------------------------------------------------------------------
// imhq_pkg
// Shared types and codes for the indexed max-heap queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imhq_pkg;

	localparam int ID_W    = 8;
	localparam int VAL_W   = 16;
	localparam int ID_SPACE = 256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_ABSENT  = 2'd3;

	// One heap slot.
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [VAL_W-1:0] start;
		logic [VAL_W-1:0] key;
	} slot_t;

	// Datapath commands.
	typedef struct packed {
		logic load;       // capture the input beat
		logic mapchk;     // read position map of the input id
		logic ins_wr;     // write new entry at the tail
		logic del_rdlast; // read last slot
		logic del_mv;     // move last slot into freed slot
		logic rd_par;     // read parent of current
		logic rd_l;       // read left child
		logic rd_r;       // read right child
		logic sw_up;      // swap current with parent
		logic sw_dn;      // swap current with chosen child
		logic rd_head;    // read slot zero
		logic done;       // finish, set status
		logic [1:0] stat;
	} cmd_t;

	// Datapath status.
	typedef struct packed {
		logic is_del;
		logic present;
		logic full;
		logic empty_after;
		logic moved;      // delete left a slot to fill
		logic at_root;
		logic up_go;
		logic has_l;
		logic has_r;
		logic dn_go;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/imhq_dp.sv =====
//------------------------------------------------------------------------------
// imhq_dp
// Heap memory, position map and sift datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imhq_dp #(
	parameter int CAPACITY = 256
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire imhq_pkg::cmd_t   cmd,
	output imhq_pkg::stat_t       st,
	input  wire                   op,
	input  wire [7:0]             entry_id,
	input  wire [15:0]            start_point,
	input  wire [15:0]            priority_key,
	output logic                  head_valid,
	output logic [7:0]            head_id,
	output logic [15:0]           head_start,
	output logic [15:0]           head_key,
	output logic [8:0]            entry_count,
	output logic [1:0]            status
);

	localparam int IDX_W = 8;
	localparam int EFF_CAP =
		(CAPACITY < imhq_pkg::ID_SPACE) ? CAPACITY : imhq_pkg::ID_SPACE;

	imhq_pkg::slot_t heap_mem [imhq_pkg::ID_SPACE];
	logic [IDX_W-1:0] pos_mem [imhq_pkg::ID_SPACE];
	logic [imhq_pkg::ID_SPACE-1:0] present_q;

	logic             op_q;
	imhq_pkg::slot_t  in_q;
	logic [8:0]       fill_q;
	logic [IDX_W-1:0] cur_q;
	imhq_pkg::slot_t  cur_d_q, l_d_q, rd_q;
	logic [IDX_W-1:0] pos_rd_q;

	logic [8:0] left_w, right_w;
	logic [IDX_W-1:0] par_w;
	logic [IDX_W-1:0] last_w;
	logic [IDX_W-1:0] child_w;
	imhq_pkg::slot_t  child_d_w;

	// Second write of a swap goes back to the vacated slot in the following cycle.
	logic             wb_q;
	logic [IDX_W-1:0] wb_idx_q;
	imhq_pkg::slot_t  wb_d_q;

	assign left_w  = {cur_q, 1'b1};
	assign right_w = {cur_q, 1'b0} + 9'd2;
	assign par_w   = (cur_q - 8'd1) >> 1;
	assign last_w  = fill_q[IDX_W-1:0] - 8'd1;

	// Right child wins only on a strictly larger key.
	always_comb begin
		child_d_w = l_d_q;
		child_w   = left_w[IDX_W-1:0];
		if (st.has_r && (l_d_q.key < rd_q.key)) begin
			child_d_w = rd_q;
			child_w   = right_w[IDX_W-1:0];
		end
	end

	// The parent read lands in rd_q for the cycle of the compare.
	always_comb begin
		st.is_del      = op_q;
		st.present     = present_q[in_q.id];
		st.full        = (fill_q >= 9'(EFF_CAP));
		st.empty_after = (fill_q == 9'd0);
		st.moved       = ({1'b0, pos_rd_q} != fill_q);
		st.at_root     = (cur_q == '0);
		st.up_go       = (rd_q.key < cur_d_q.key);
		st.has_l       = (left_w < fill_q);
		st.has_r       = (right_w < fill_q);
		st.dn_go       = (cur_d_q.key < child_d_w.key);
	end

	// Heap and map memories: one read and one write port each.
	always_ff @(posedge clk) begin
		if (cmd.rd_par)
			rd_q <= heap_mem[par_w];
		else if (cmd.rd_l)
			rd_q <= heap_mem[left_w[IDX_W-1:0]];
		else if (cmd.rd_r)
			rd_q <= heap_mem[right_w[IDX_W-1:0]];
		else if (cmd.del_rdlast)
			rd_q <= heap_mem[last_w];
		else if (cmd.rd_head)
			rd_q <= heap_mem[0];
		pos_rd_q <= pos_rd_q;
		if (cmd.mapchk)
			pos_rd_q <= pos_mem[in_q.id];
		if (cmd.ins_wr) begin
			heap_mem[fill_q[IDX_W-1:0]] <= in_q;
			pos_mem[in_q.id] <= fill_q[IDX_W-1:0];
		end else if (cmd.del_mv) begin
			heap_mem[pos_rd_q] <= rd_q;
			pos_mem[rd_q.id] <= pos_rd_q;
		end else if (cmd.sw_up) begin
			heap_mem[par_w] <= cur_d_q;
			pos_mem[cur_d_q.id] <= par_w;
		end else if (cmd.sw_dn) begin
			heap_mem[child_w] <= cur_d_q;
			pos_mem[cur_d_q.id] <= child_w;
		end else if (wb_q) begin
			heap_mem[wb_idx_q] <= wb_d_q;
			pos_mem[wb_d_q.id] <= wb_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= 1'b0;
		end else begin
			wb_q <= cmd.sw_up || cmd.sw_dn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sw_up) begin
			wb_idx_q <= cur_q;
			wb_d_q   <= rd_q;
		end else if (cmd.sw_dn) begin
			wb_idx_q <= cur_q;
			wb_d_q   <= child_d_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			fill_q      <= '0;
			op_q        <= 1'b0;
			head_valid  <= 1'b0;
			entry_count <= '0;
			status      <= imhq_pkg::ST_OK;
		end else begin
			if (cmd.load)
				op_q <= op;
			if (cmd.ins_wr) begin
				present_q[in_q.id] <= 1'b1;
				fill_q <= fill_q + 9'd1;
			end
			if (cmd.del_rdlast) begin
				present_q[in_q.id] <= 1'b0;
				fill_q <= fill_q - 9'd1;
			end
			if (cmd.done) begin
				status      <= cmd.stat;
				entry_count <= fill_q;
				head_valid  <= (fill_q != 9'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q.id    <= entry_id;
			in_q.start <= start_point;
			in_q.key   <= priority_key;
		end
		if (cmd.ins_wr) begin
			cur_q   <= fill_q[IDX_W-1:0];
			cur_d_q <= in_q;
		end
		if (cmd.del_mv) begin
			cur_q   <= pos_rd_q;
			cur_d_q <= rd_q;
		end
		if (cmd.rd_r)
			l_d_q <= rd_q;
		if (cmd.sw_up)
			cur_q <= par_w;
		if (cmd.sw_dn)
			cur_q <= child_w;
		if (cmd.done) begin
			head_id    <= (fill_q != 9'd0) ? rd_q.id : '0;
			head_start <= (fill_q != 9'd0) ? rd_q.start : '0;
			head_key   <= (fill_q != 9'd0) ? rd_q.key : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/imhq_ctrl.sv =====
//------------------------------------------------------------------------------
// imhq_ctrl
// Sequencer for insert, delete and the sift loops.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imhq_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output imhq_pkg::cmd_t      cmd,
	input  wire imhq_pkg::stat_t st
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_MAP   = 4'd2;
	localparam logic [3:0] S_LAST  = 4'd3;
	localparam logic [3:0] S_MOVE  = 4'd4;
	localparam logic [3:0] S_UPRD  = 4'd5;
	localparam logic [3:0] S_UPCMP = 4'd6;
	localparam logic [3:0] S_DNL   = 4'd7;
	localparam logic [3:0] S_DNR   = 4'd8;
	localparam logic [3:0] S_DNCMP = 4'd9;
	localparam logic [3:0] S_HEAD  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;
	localparam logic [3:0] S_WB    = 4'd13;

	logic [3:0] state_q, state_d;
	logic [1:0] stat_q, stat_d;
	logic       moved_up_q, moved_up_d;
	logic       del_mode_q, del_mode_d;

	always_comb begin
		state_d    = state_q;
		stat_d     = stat_q;
		moved_up_d = moved_up_q;
		del_mode_d = del_mode_q;
		cmd        = '0;
		cmd.stat   = stat_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				cmd.mapchk = 1'b1;
				moved_up_d = 1'b0;
				del_mode_d = st.is_del;
				if (!st.is_del) begin
					if (st.full) begin
						stat_d  = imhq_pkg::ST_FULL;
						state_d = S_HEAD;
					end else if (st.present) begin
						stat_d  = imhq_pkg::ST_PRESENT;
						state_d = S_HEAD;
					end else begin
						stat_d  = imhq_pkg::ST_OK;
						state_d = S_MAP;
					end
				end else if (!st.present) begin
					stat_d  = imhq_pkg::ST_ABSENT;
					state_d = S_HEAD;
				end else begin
					stat_d  = imhq_pkg::ST_OK;
					state_d = S_MAP;
				end
			end
			S_MAP: begin
				if (del_mode_q) begin
					cmd.del_rdlast = 1'b1;
					state_d = S_LAST;
				end else begin
					cmd.ins_wr = 1'b1;
					state_d = S_UPRD;
				end
			end
			S_LAST: state_d = st.moved ? S_MOVE : S_HEAD;
			S_MOVE: begin
				cmd.del_mv = 1'b1;
				state_d = S_UPRD;
			end
			S_UPRD: begin
				if (st.at_root) begin
					state_d = del_mode_q && !moved_up_q ? S_DNL : S_HEAD;
				end else begin
					cmd.rd_par = 1'b1;
					state_d = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (st.up_go) begin
					cmd.sw_up  = 1'b1;
					moved_up_d = 1'b1;
					state_d    = S_WB;
				end else begin
					state_d = del_mode_q && !moved_up_q ? S_DNL : S_HEAD;
				end
			end
			S_WB: state_d = moved_up_q ? S_UPRD : S_DNL;
			S_DNL: begin
				if (!st.has_l) begin
					state_d = S_HEAD;
				end else begin
					cmd.rd_l = 1'b1;
					state_d = S_DNR;
				end
			end
			S_DNR: begin
				cmd.rd_r = 1'b1;
				state_d = S_DNCMP;
			end
			S_DNCMP: begin
				if (st.dn_go) begin
					cmd.sw_dn = 1'b1;
					state_d   = S_WB;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.rd_head = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.done = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			stat_q     <= imhq_pkg::ST_OK;
			moved_up_q <= 1'b0;
			del_mode_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			stat_q     <= stat_d;
			moved_up_q <= moved_up_d;
			del_mode_q <= del_mode_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/indexed_max_heap_queue_top.sv =====
// Indexed max-heap priority queue. One beat in gives one beat out, and the next input
// beat is taken only once the result has been accepted. A rejected operation goes straight
// to reading the head, an insert writes the tail slot and sifts up, a delete of the last
// slot only shrinks the heap, and any other delete moves the last slot into the freed one
// and sifts it up or down. Every sift step goes through the single read and write port
// of the heap memory, which sets the time an operation takes.
//------------------------------------------------------------------------------
// indexed_max_heap_queue_top
// Top level: controller and datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_max_heap_queue_top #(
	parameter int CAPACITY = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         op,
	input  wire [7:0]   entry_id,
	input  wire [15:0]  start_point,
	input  wire [15:0]  priority_key,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        head_valid,
	output logic [7:0]  head_id,
	output logic [15:0] head_start,
	output logic [15:0] head_key,
	output logic [8:0]  entry_count,
	output logic [1:0]  status
);

	imhq_pkg::cmd_t  cmd;
	imhq_pkg::stat_t st;

	imhq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .st(st)
	);

	imhq_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .op(op),
		.entry_id(entry_id), .start_point(start_point), .priority_key(priority_key),
		.head_valid(head_valid), .head_id(head_id), .head_start(head_start),
		.head_key(head_key), .entry_count(entry_count), .status(status)
	);

endmodule

`default_nettype wire

// ===== hdl/imhq_checker.sv =====
//------------------------------------------------------------------------------
// imhq_checker
// Port-level checks on the heap queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_max_heap_queue_top_defines.svh"

module imhq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        head_valid,
	input wire [8:0]  entry_count,
	input wire [1:0]  status
);

	// One item at a time: no new beat is taken while a result waits.
	`IMHQ_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input while pending")
	// Head is valid exactly when the queue holds entries.
	`IMHQ_ASSERT_IMP(a_head_cnt, clk, arst_n, out_valid, head_valid == (entry_count != 9'd0), "head")
	// A full status is never reported with an empty queue.
	`IMHQ_ASSERT_IMP(a_full_cnt, clk, arst_n, out_valid && status == imhq_pkg::ST_FULL, entry_count != 9'd0, "full")
	// A result is held until taken.
	`IMHQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(entry_count), "dropped")

	logic unused_in_valid;
	assign unused_in_valid = in_valid;

endmodule

bind indexed_max_heap_queue_top imhq_checker u_imhq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .head_valid(head_valid),
	.entry_count(entry_count), .status(status)
);

`default_nettype wire

// ===== tb/imhq_checker.sv =====
//------------------------------------------------------------------------------
// imhq_scoreboard
// Watches both channels of the indexed max-heap queue, keeps its own model of
// the heap and position map, and compares every result beat field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imhq_scoreboard #(
	parameter int CAPACITY = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire         op,
	input  wire [7:0]   entry_id,
	input  wire [15:0]  start_point,
	input  wire [15:0]  priority_key,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire         head_valid,
	input  wire [7:0]   head_id,
	input  wire [15:0]  head_start,
	input  wire [15:0]  head_key,
	input  wire [8:0]   entry_count,
	input  wire [1:0]   status,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        hv;
		logic [7:0]  hid;
		logic [15:0] hstart;
		logic [15:0] hkey;
		logic [8:0]  cnt;
		logic [1:0]  st;
	} head_report_t;

	imhq_pkg::slot_t heap [imhq_pkg::ID_SPACE];
	bit              id_held [imhq_pkg::ID_SPACE];
	int              id_slot [imhq_pkg::ID_SPACE];
	int              fill;
	head_report_t    head_reports [$];

	initial fail_count = 0;
	initial pending = 0;
	initial fill = 0;

	task automatic report(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void swap_entries(input int a, input int b);
		imhq_pkg::slot_t t;
		t = heap[a];
		heap[a] = heap[b];
		heap[b] = t;
		id_slot[heap[a].id] = a;
		id_slot[heap[b].id] = b;
	endfunction

	function automatic int bubble_up(input int n);
		int p;
		while (n > 0) begin
			p = (n - 1) / 2;
			if (heap[p].key < heap[n].key) begin
				swap_entries(p, n);
				n = p;
			end else
				break;
		end
		return n;
	endfunction

	function automatic void bubble_down(input int n);
		int l, c;
		forever begin
			l = 2 * n + 1;
			if (l >= fill)
				break;
			c = l;
			if (l + 1 < fill && heap[l].key < heap[l + 1].key)
				c = l + 1;
			if (heap[n].key < heap[c].key) begin
				swap_entries(n, c);
				n = c;
			end else
				break;
		end
	endfunction

	function automatic head_report_t apply_beat(input logic o, input logic [7:0] id,
			input logic [15:0] sp, input logic [15:0] k);
		head_report_t r;
		int p, last;
		r = '0;
		r.st = imhq_pkg::ST_OK;
		if (o == imhq_pkg::OP_INSERT) begin
			if (fill >= CAPACITY || fill >= imhq_pkg::ID_SPACE)
				r.st = imhq_pkg::ST_FULL;
			else if (id_held[id])
				r.st = imhq_pkg::ST_PRESENT;
			else begin
				heap[fill] = '{id: id, start: sp, key: k};
				id_held[id] = 1'b1;
				id_slot[id] = fill;
				fill++;
				void'(bubble_up(fill - 1));
			end
		end else begin
			if (!id_held[id] || fill == 0)
				r.st = imhq_pkg::ST_ABSENT;
			else begin
				p = id_slot[id];
				last = fill - 1;
				id_held[id] = 1'b0;
				fill = last;
				if (p < last) begin
					heap[p] = heap[last];
					id_slot[heap[p].id] = p;
					if (bubble_up(p) == p)
						bubble_down(p);
				end
			end
		end
		if (fill > 0) begin
			r.hv = 1'b1;
			r.hid = heap[0].id;
			r.hstart = heap[0].start;
			r.hkey = heap[0].key;
		end
		r.cnt = fill[8:0];
		return r;
	endfunction

	always @(posedge clk) begin
		head_report_t w;
		if (arst_n) begin
			if (in_valid && in_ready)
				head_reports.insert(head_reports.size(),
					apply_beat(op, entry_id, start_point, priority_key));
			if (out_valid && out_ready) begin
				if (head_reports.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					w = head_reports.pop_front();
					if (head_valid !== w.hv) report("head_valid", head_valid, w.hv);
					if (head_id !== w.hid) report("head_id", head_id, w.hid);
					if (head_start !== w.hstart) report("head_start", head_start, w.hstart);
					if (head_key !== w.hkey) report("head_key", head_key, w.hkey);
					if (entry_count !== w.cnt) report("entry_count", entry_count, w.cnt);
					if (status !== w.st) report("status", status, w.st);
				end
			end
			pending = head_reports.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
//------------------------------------------------------------------------------
// tb
// Regression for the indexed max-heap queue: directed corner cases, then
// random insert/delete traffic in several idle and stall phases.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = imhq_pkg::OP_INSERT;
	logic [7:0]  entry_id = '0;
	logic [15:0] start_point = '0;
	logic [15:0] priority_key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        head_valid;
	logic [7:0]  head_id;
	logic [15:0] head_start;
	logic [15:0] head_key;
	logic [8:0]  entry_count;
	logic [1:0]  status;
	int          fail_count;
	int          pending;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_off = 0;
	bit          held [256];
	int          beats_sent = 0;

	always #4 clk = ~clk;

	indexed_max_heap_queue_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .entry_id(entry_id), .start_point(start_point),
		.priority_key(priority_key),
		.out_valid(out_valid), .out_ready(out_ready),
		.head_valid(head_valid), .head_id(head_id), .head_start(head_start),
		.head_key(head_key), .entry_count(entry_count), .status(status)
	);

	imhq_scoreboard i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .entry_id(entry_id), .start_point(start_point),
		.priority_key(priority_key),
		.out_valid(out_valid), .out_ready(out_ready),
		.head_valid(head_valid), .head_id(head_id), .head_start(head_start),
		.head_key(head_key), .entry_count(entry_count), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: random stalls, or a long hold-off counted here.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Valid stays high from one beat to the next unless the sender idles.
	task automatic send_beat(input logic o, input logic [7:0] id,
			input logic [15:0] sp, input logic [15:0] k);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		entry_id <= id;
		start_point <= sp;
		priority_key <= k;
		do
			@(posedge clk);
		while (!in_ready);
		if (o == imhq_pkg::OP_INSERT)
			held[id] = 1'b1;
		else
			held[id] = 1'b0;
		beats_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// Mostly valid traffic: deletes of held ids, inserts of free ids, with
	// some duplicate inserts and absent deletes mixed in.
	task automatic random_traffic(input int n, input int ins_bias);
		logic [7:0] id;
		int tries;
		for (int i = 0; i < n; i++) begin
			id = 8'($urandom_range(255));
			if ($urandom_range(99) < ins_bias) begin
				tries = 0;
				while (held[id] && tries < 8 && $urandom_range(9) != 0) begin
					id = 8'($urandom_range(255));
					tries++;
				end
				send_beat(imhq_pkg::OP_INSERT, id, 16'($urandom),
					($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom));
			end else begin
				tries = 0;
				while (!held[id] && tries < 16 && $urandom_range(9) != 0) begin
					id = 8'($urandom_range(255));
					tries++;
				end
				send_beat(imhq_pkg::OP_DELETE, id, 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		#2000000;
		$display("timeout");
		$display("indexed_max_heap_queue_top regression: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty delete, extremes, duplicates, equal keys, ties.
		send_beat(imhq_pkg::OP_DELETE, 8'd0, 16'hffff, 16'hffff);
		send_beat(imhq_pkg::OP_INSERT, 8'd0, 16'h0000, 16'h0000);
		send_beat(imhq_pkg::OP_INSERT, 8'd255, 16'hffff, 16'hffff);
		send_beat(imhq_pkg::OP_INSERT, 8'd255, 16'h1234, 16'h0001);
		send_beat(imhq_pkg::OP_INSERT, 8'd10, 16'haaaa, 16'h5555);
		send_beat(imhq_pkg::OP_INSERT, 8'd11, 16'h5555, 16'h5555);
		send_beat(imhq_pkg::OP_INSERT, 8'd12, 16'h0f0f, 16'hffff);
		send_beat(imhq_pkg::OP_INSERT, 8'd13, 16'hf0f0, 16'h5555);
		send_beat(imhq_pkg::OP_DELETE, 8'd255, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd200, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd12, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd0, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd10, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd11, 16'h0, 16'h0);
		send_beat(imhq_pkg::OP_DELETE, 8'd13, 16'h0, 16'h0);
		// The sender waits for every result before going on.
		drain_results();

		// Phase of no idling, with one long receiver hold-off while traffic flows.
		hold_off = 300;
		random_traffic(100, 60);
		drain_results();

		// Fill the heap completely, then hit the full case, also with ids already held.
		for (int i = 0; i < 256; i++)
			if (!held[i])
				send_beat(imhq_pkg::OP_INSERT, i[7:0], 16'($urandom), 16'($urandom));
		send_beat(imhq_pkg::OP_INSERT, 8'd77, 16'h1, 16'h1);
		send_beat(imhq_pkg::OP_INSERT, 8'd0, 16'h2, 16'h2);
		drain_results();

		send_idle_pct = 57;
		random_traffic(130, 40);
		send_idle_pct = 0;
		stall_pct = 57;
		random_traffic(130, 55);
		send_idle_pct = 32;
		stall_pct = 32;
		random_traffic(130, 50);
		send_idle_pct = 0;
		stall_pct = 0;
		random_traffic(110, 45);
		drain_results();
		repeat (60) @(posedge clk);

		$display("covered %0d beats: empty, full, duplicate and absent cases, equal keys,",
			beats_sent);
		$display("and random traffic under sender idling and receiver stalls");
		if (fail_count == 0 && pending == 0)
			$display("indexed_max_heap_queue_top regression: pass");
		else
			$display("indexed_max_heap_queue_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
